/* rtl/fpid_pkg.sv */
package fpid_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  // product after the fraction shift, and the width of the three-term sum
  localparam int PROD_W    = 2 * DATA_W - FRAC_BITS;
  localparam int SUM_W     = PROD_W + 2;
  localparam int ADDR_W    = 5;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic [2:0] {
    REG_GAIN_PROP          = 3'd0,
    REG_GAIN_INTEGRAL_DT   = 3'd1,
    REG_GAIN_DERIV_OVER_DT = 3'd2,
    REG_LIMIT_LOW          = 3'd3,
    REG_LIMIT_HIGH         = 3'd4
  } reg_idx_t;

  typedef struct packed {
    word_t gain_prop;
    word_t gain_integral_dt;
    word_t gain_deriv_over_dt;
    word_t limit_low;
    word_t limit_high;
  } cfg_t;

  // terms of one word, held between the multiplier stage and the accumulator
  typedef struct packed {
    logic  func;
    prod_t p;
    prod_t ip;
    prod_t d;
    word_t pre;
  } terms_t;

  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // saturating difference a - b
  function automatic word_t sat_diff(word_t a, word_t b);
    logic signed [DATA_W:0] x;
    x = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (x[DATA_W] != x[DATA_W-1]) begin
      return x[DATA_W] ? WORD_MIN : WORD_MAX;
    end
    return x[DATA_W-1:0];
  endfunction

  // exact product, arithmetic shift right by the fraction bits
  function automatic prod_t fmul(word_t a, word_t b);
    logic signed [2*DATA_W-1:0] p;
    p = a * b;
    return PROD_W'(p >>> FRAC_BITS);
  endfunction

  // clamp: above low gives min(x, high), anything else gives low
  function automatic word_t lim(sum_t x, word_t lo, word_t hi);
    sum_t l;
    sum_t h;
    l = SUM_W'(lo);
    h = SUM_W'(hi);
    if (x > l) begin
      return (x < h) ? DATA_W'(x) : hi;
    end
    return lo;
  endfunction

endpackage

/* rtl/fpid_cfg.sv */
module fpid_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fpid_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output fpid_pkg::cfg_t             cfg
);

  fpid_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = fpid_pkg::reg_idx_t'(paddr[fpid_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_prop          <= '0;
      cfg.gain_integral_dt   <= '0;
      cfg.gain_deriv_over_dt <= '0;
      cfg.limit_low          <= fpid_pkg::WORD_MIN;
      cfg.limit_high         <= fpid_pkg::WORD_MAX;
    end else if (wr) begin
      unique case (idx)
        fpid_pkg::REG_GAIN_PROP:          cfg.gain_prop          <= pwdata;
        fpid_pkg::REG_GAIN_INTEGRAL_DT:   cfg.gain_integral_dt   <= pwdata;
        fpid_pkg::REG_GAIN_DERIV_OVER_DT: cfg.gain_deriv_over_dt <= pwdata;
        fpid_pkg::REG_LIMIT_LOW:          cfg.limit_low          <= pwdata;
        fpid_pkg::REG_LIMIT_HIGH:         cfg.limit_high         <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      fpid_pkg::REG_GAIN_PROP:          prdata = cfg.gain_prop;
      fpid_pkg::REG_GAIN_INTEGRAL_DT:   prdata = cfg.gain_integral_dt;
      fpid_pkg::REG_GAIN_DERIV_OVER_DT: prdata = cfg.gain_deriv_over_dt;
      fpid_pkg::REG_LIMIT_LOW:          prdata = cfg.limit_low;
      fpid_pkg::REG_LIMIT_HIGH:         prdata = cfg.limit_high;
      default:                          prdata = '0;
    endcase
  end

endmodule

/* rtl/fpid_front.sv */
module fpid_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  func,
  input  fpid_pkg::word_t       measurement,
  input  fpid_pkg::word_t       target,
  input  fpid_pkg::word_t       preset_output,
  input  fpid_pkg::cfg_t        cfg,
  input  logic                  take,
  output logic                  terms_valid,
  output fpid_pkg::terms_t      terms
);

  logic            in_full;
  logic            func_q;
  fpid_pkg::word_t meas_q;
  fpid_pkg::word_t tgt_q;
  fpid_pkg::word_t pre_q;
  fpid_pkg::word_t prev_meas;
  fpid_pkg::word_t err;
  fpid_pkg::word_t dmeas;
  logic            adv;

  assign adv        = in_full && (!terms_valid || take);
  assign item_stall = in_full && !adv;

  assign err   = fpid_pkg::sat_diff(meas_q, tgt_q);
  assign dmeas = fpid_pkg::sat_diff(meas_q, prev_meas);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full     <= 1'b0;
      terms_valid <= 1'b0;
      prev_meas   <= '0;
    end else begin
      if (!item_stall) begin
        in_full <= item_valid;
      end
      if (adv) begin
        terms_valid <= 1'b1;
        prev_meas   <= meas_q;
      end else if (take) begin
        terms_valid <= 1'b0;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      func_q <= func;
      meas_q <= measurement;
      tgt_q  <= target;
      pre_q  <= preset_output;
    end
  end

  // multiplier register
  always_ff @(posedge clk) begin
    if (adv) begin
      terms.func <= func_q;
      terms.p    <= fpid_pkg::fmul(cfg.gain_prop, err);
      terms.ip   <= fpid_pkg::fmul(cfg.gain_integral_dt, err);
      terms.d    <= fpid_pkg::fmul(cfg.gain_deriv_over_dt, dmeas);
      terms.pre  <= fpid_pkg::lim(fpid_pkg::SUM_W'(pre_q), cfg.limit_low, cfg.limit_high);
    end
  end

endmodule

/* rtl/fpid_acc.sv */
module fpid_acc (
  input  logic             clk,
  input  logic             rst,
  input  logic             terms_valid,
  input  fpid_pkg::terms_t terms,
  input  fpid_pkg::cfg_t   cfg,
  output logic             take,
  output logic             result_valid,
  input  logic             result_stall,
  output fpid_pkg::word_t  drive
);

  fpid_pkg::word_t integral_acc;
  fpid_pkg::word_t integral_next;
  fpid_pkg::word_t drive_next;
  fpid_pkg::sum_t  int_sum;
  fpid_pkg::sum_t  total;
  logic            out_free;
  logic            emit;

  assign out_free = !result_valid || !result_stall;
  // preset words need no output slot
  assign take     = terms_valid && (terms.func || out_free);
  assign emit     = take && !terms.func;

  always_comb begin
    int_sum       = fpid_pkg::SUM_W'(integral_acc) + fpid_pkg::SUM_W'(terms.ip);
    integral_next = fpid_pkg::lim(int_sum, cfg.limit_low, cfg.limit_high);
    total         = fpid_pkg::SUM_W'(terms.p) + fpid_pkg::SUM_W'(integral_next)
                  + fpid_pkg::SUM_W'(terms.d);
    drive_next    = fpid_pkg::lim(total, cfg.limit_low, cfg.limit_high);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        integral_acc <= terms.func ? terms.pre : integral_next;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (out_free) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      drive <= drive_next;
    end
  end

endmodule

/* rtl/fixed_point_pid_controller_core.sv */
// Q16.16 PID controller with the derivative taken on the measurement. Each
// input word (func = 0) forms error = measurement - target, updates the
// clamped integral, adds the proportional, integral and derivative terms at
// full width and returns the sum clamped to limit_low/limit_high on drive.
// A preset word (func = 1) loads the clamped preset_output into the integral
// and the measurement into the last-measurement register, and returns
// nothing. One word is taken every clock cycle while drive is not stalled.
// A word passes from the input register to the multiplier register and on
// to the result register, from which drive is taken. The three 32x32
// multiplies share one stage and the integral update and output clamp share
// the next, so the integral loop closes within the accumulator stage. A
// stalled drive word holds any compute word behind it (preset words still
// pass the multiplier stage), and the input stalls once both stages are
// full. Registers sit on the APB-style port at byte addresses
// 0x00 gain_prop, 0x04 gain_integral_dt, 0x08 gain_deriv_over_dt,
// 0x0C limit_low and 0x10 limit_high; write them only while the block is
// idle.
module fixed_point_pid_controller_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpid_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic                        func,
  input  logic signed [31:0]          measurement,
  input  logic signed [31:0]          target,
  input  logic signed [31:0]          preset_output,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic signed [31:0]          drive
);

  fpid_pkg::cfg_t   cfg;
  fpid_pkg::terms_t terms;
  logic             terms_valid;
  logic             take;

  // register bank
  fpid_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register, differences and the three products
  fpid_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .func          (func),
    .measurement   (measurement),
    .target        (target),
    .preset_output (preset_output),
    .cfg           (cfg),
    .take          (take),
    .terms_valid   (terms_valid),
    .terms         (terms)
  );

  // integral state, three-term sum and the result register
  fpid_acc u_acc (
    .clk          (clk),
    .rst          (rst),
    .terms_valid  (terms_valid),
    .terms        (terms),
    .cfg          (cfg),
    .take         (take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .drive        (drive)
  );

`ifndef SYNTHESIS
  // a result only ever rises from a compute word leaving the product stage
  a_rise_from_compute: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(take && !terms.func))
    else $error("result raised without a compute word");

  // a compute word taken by the accumulator always shows a result next
  a_compute_emits: assert property (@(posedge clk) disable iff (rst)
    (take && !terms.func) |=> result_valid)
    else $error("compute word dropped");

  // stalling the input only ever happens with the product stage full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> terms_valid)
    else $error("input stalled with the product stage empty");

  // the product stage is only drained by a take
  a_terms_hold: assert property (@(posedge clk) disable iff (rst)
    (terms_valid && !take) |=> terms_valid)
    else $error("product stage lost a word");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

  // Q16.16 unity, and the spare register slots beyond the last real register
  localparam fpid_pkg::word_t ONE = 32'sh0001_0000;
  localparam logic [2:0] REG_SPARE_LO = 3'(fpid_pkg::REG_LIMIT_HIGH + 1);
  localparam logic [2:0] REG_SPARE_HI = '1;

  // drain waits for every due drive word; a preset word leaves nothing
  // behind to wait for, so hold this many cycles before touching registers
  localparam int SETTLE = 8;
  localparam int PHASES = 10;
  localparam int PHASE_WORDS = 190;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PLAN_LEN = 29;

  typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_t;

  // one directed step: a register write (value in a) or an input word;
  // where typed is set the drive value is read straight off the row
  typedef struct packed {
    row_kind_t       kind;
    logic [2:0]      idx;
    logic            func;
    fpid_pkg::word_t a;
    fpid_pkg::word_t b;
    fpid_pkg::word_t c;
    logic            typed;
    fpid_pkg::word_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [fpid_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic item_valid = 1'b0;
  logic item_stall;
  logic func = 1'b0;
  logic signed [31:0] measurement = '0;
  logic signed [31:0] target = '0;
  logic signed [31:0] preset_output = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [31:0] drive;

  fixed_point_pid_controller_core dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .func(func),
    .measurement(measurement),
    .target(target),
    .preset_output(preset_output),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .drive(drive)
  );

  // mirror of the register file and of the controller state, held wide so
  // the three-term sum never wraps before it is clamped
  longint kp = 0;
  longint ki_dt = 0;
  longint kd_dt = 0;
  longint lim_lo = -longint'(2) ** 31;
  longint lim_hi = longint'(2) ** 31 - 1;
  longint integ_model = 0;
  longint last_meas = 0;

  fpid_pkg::word_t drive_due [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit idling_on = 1'b1;

  // directed plan: reset values, saturating differences, extreme gains,
  // crossed limits, equal limits and writes to the spare register slots
  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b0, 32'sh0064_0000, '0, '0, 1'b1, '0},
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b1, ONE, 32'sh0042_0000, 32'sh0003_0000,
      1'b0, '0},
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b0, 32'sh0002_0000, fpid_pkg::WORD_MAX,
      '0, 1'b1, 32'sh0003_0000},
    '{ROW_WRITE, fpid_pkg::REG_GAIN_PROP, 1'b0, ONE, '0, '0, 1'b0, '0},
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b0, fpid_pkg::WORD_MAX, fpid_pkg::WORD_MIN,
      '0, 1'b1, fpid_pkg::WORD_MAX},
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b0, fpid_pkg::WORD_MIN, fpid_pkg::WORD_MAX,
      '0, 1'b0, '0},
    '{ROW_WRITE, fpid_pkg::REG_GAIN_PROP, 1'b0, '0, '0, '0, 1'b0, '0},
    '{ROW_WRITE, fpid_pkg::REG_GAIN_DERIV_OVER_DT, 1'b0, ONE, '0, '0, 1'b0, '0},
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b1, fpid_pkg::WORD_MIN, '0,
      fpid_pkg::WORD_MIN, 1'b0, '0},
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b0, fpid_pkg::WORD_MAX, fpid_pkg::WORD_MAX,
      '0, 1'b0, '0},
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b0, fpid_pkg::WORD_MIN, '0, '0, 1'b0, '0},
    '{ROW_WRITE, fpid_pkg::REG_GAIN_INTEGRAL_DT, 1'b0, fpid_pkg::WORD_MAX, '0, '0,
      1'b0, '0},
    '{ROW_WRITE, fpid_pkg::REG_GAIN_PROP, 1'b0, fpid_pkg::WORD_MIN, '0, '0, 1'b0, '0},
    '{ROW_WRITE, fpid_pkg::REG_GAIN_DERIV_OVER_DT, 1'b0, fpid_pkg::WORD_MIN, '0, '0,
      1'b0, '0},
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b0, fpid_pkg::WORD_MAX, fpid_pkg::WORD_MIN,
      '0, 1'b0, '0},
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b0, fpid_pkg::WORD_MIN, fpid_pkg::WORD_MAX,
      '0, 1'b0, '0},
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b0, '0, '0, fpid_pkg::WORD_MAX, 1'b0, '0},
    '{ROW_WRITE, fpid_pkg::REG_LIMIT_LOW, 1'b0, ONE, '0, '0, 1'b0, '0},
    '{ROW_WRITE, fpid_pkg::REG_LIMIT_HIGH, 1'b0, 32'shFFFF_0000, '0, '0, 1'b0, '0},
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b1, '0, fpid_pkg::WORD_MIN,
      fpid_pkg::WORD_MAX, 1'b0, '0},
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b0, 32'sh0000_0010, 32'sh0000_0020, '0,
      1'b0, '0},
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b0, fpid_pkg::WORD_MIN, fpid_pkg::WORD_MIN,
      '0, 1'b0, '0},
    '{ROW_WRITE, REG_SPARE_LO, 1'b0, ONE, '0, '0, 1'b0, '0},
    '{ROW_WRITE, REG_SPARE_HI, 1'b0, fpid_pkg::WORD_MAX, '0, '0, 1'b0, '0},
    '{ROW_WRITE, fpid_pkg::REG_LIMIT_LOW, 1'b0, 32'sh0005_0000, '0, '0, 1'b0, '0},
    '{ROW_WRITE, fpid_pkg::REG_LIMIT_HIGH, 1'b0, 32'sh0005_0000, '0, '0, 1'b0, '0},
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b0, 32'sh1234_5678, 32'shEDCB_A988, '0,
      1'b1, 32'sh0005_0000},
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b1, 32'sh0007_0000, '0, '0, 1'b0, '0},
    '{ROW_WORD,  fpid_pkg::REG_GAIN_PROP, 1'b0, fpid_pkg::WORD_MIN, fpid_pkg::WORD_MAX,
      '0, 1'b1, 32'sh0005_0000}
  };

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog: give up well past the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic longint sat_word(longint x);
    if (x > longint'(fpid_pkg::WORD_MAX)) return longint'(fpid_pkg::WORD_MAX);
    if (x < longint'(fpid_pkg::WORD_MIN)) return longint'(fpid_pkg::WORD_MIN);
    return x;
  endfunction

  // above the low limit gives min(x, high); anything else gives the low limit,
  // which is also what happens when the limits are crossed
  function automatic longint clamp_out(longint x);
    return (x > lim_lo) ? ((x < lim_hi) ? x : lim_hi) : lim_lo;
  endfunction

  // exact product, floor shift by the fraction bits
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> fpid_pkg::FRAC_BITS;
  endfunction

  // advance the controller mirror by one word; return 1 where a drive is due
  function automatic bit pid_predict(logic f, fpid_pkg::word_t m, fpid_pkg::word_t t,
                                     fpid_pkg::word_t p, output fpid_pkg::word_t y);
    longint err;
    longint pt;
    longint dt;
    y = '0;
    if (f) begin
      integ_model = clamp_out(longint'(p));
      last_meas = longint'(m);
      return 1'b0;
    end
    err = sat_word(longint'(m) - longint'(t));
    pt = fx_mul(kp, err);
    integ_model = clamp_out(integ_model + fx_mul(ki_dt, err));
    dt = fx_mul(kd_dt, sat_word(longint'(m) - last_meas));
    last_meas = longint'(m);
    y = fpid_pkg::word_t'(clamp_out(pt + integ_model + dt));
    return 1'b1;
  endfunction

  // result side: check each accepted drive word, then pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (drive_due.size() == 0) begin
          $display("%0t drive with nothing due: expected none, actual %h", $time, drive);
          mismatches <= mismatches + 1;
        end else begin
          if (drive !== drive_due[0]) begin
            $display("%0t drive mismatch: expected %h, actual %h", $time,
                     drive_due[0], drive);
            mismatches <= mismatches + 1;
          end
          void'(drive_due.pop_front());
        end
      end
      // stall in bursts whose length is drawn at random
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        result_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 9);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // APB write: setup, access, and a quiet wait with psel low so back-to-back writes
  // never drive psel twice in one step
  task automatic reg_write(input logic [2:0] idx, input fpid_pkg::word_t v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      fpid_pkg::REG_GAIN_PROP:          kp = longint'(v);
      fpid_pkg::REG_GAIN_INTEGRAL_DT:   ki_dt = longint'(v);
      fpid_pkg::REG_GAIN_DERIV_OVER_DT: kd_dt = longint'(v);
      fpid_pkg::REG_LIMIT_LOW:          lim_lo = longint'(v);
      fpid_pkg::REG_LIMIT_HIGH:         lim_hi = longint'(v);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // hold the sender until every drive word is back and the pipe is empty
  task automatic drain();
    item_valid <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // offer one word, wait for it to be taken, then log what it should produce
  task automatic send_word(input logic f, input fpid_pkg::word_t m,
                           input fpid_pkg::word_t t, input fpid_pkg::word_t p,
                           input logic typed, input fpid_pkg::word_t want);
    fpid_pkg::word_t y;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_valid <= 1'b1;
    func <= f;
    measurement <= m;
    target <= t;
    preset_output <= p;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (pid_predict(f, m, t, p, y)) begin
      drive_due.push_back(typed ? want : y);
    end
  endtask

  // extremes, full-range noise and small values so the derivative and the
  // integral see ordinary steps as well as saturation
  function automatic fpid_pkg::word_t pick_field();
    case ($urandom_range(0, 9))
      0: return fpid_pkg::WORD_MIN;
      1: return fpid_pkg::WORD_MAX;
      2: return '0;
      3, 4, 5: return fpid_pkg::word_t'($urandom);
      default: return fpid_pkg::word_t'($signed($urandom_range(0, 32'h0040_0000))
                                        - 32'sh0020_0000);
    endcase
  endfunction

  function automatic fpid_pkg::word_t pick_gain(int mode);
    case (mode)
      0: return fpid_pkg::word_t'($signed($urandom_range(0, 32'h0008_0000))
                                  - 32'sh0004_0000);
      1: return fpid_pkg::word_t'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: return fpid_pkg::WORD_MIN;
          1: return fpid_pkg::WORD_MAX;
          2: return '0;
          default: return ONE;
        endcase
      end
      default: return fpid_pkg::word_t'($signed($urandom_range(0, 32'h0002_0000))
                                        - 32'sh0001_0000);
    endcase
  endfunction

  initial begin
    fpid_pkg::word_t a;
    fpid_pkg::word_t b;
    fpid_pkg::word_t lo;
    fpid_pkg::word_t hi;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed plan, walked row by row; registers change only once idle
    for (int r = 0; r < PLAN_LEN; r++) begin
      if (plan[r].kind == ROW_WRITE) begin
        drain();
        reg_write(plan[r].idx, plan[r].a);
      end else begin
        send_word(plan[r].func, plan[r].a, plan[r].b, plan[r].c, plan[r].typed,
                  plan[r].want);
      end
    end

    // random phases, each under fresh gains and limits; the last one runs
    // without any idling on either side
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) idling_on = 1'b0;
      drain();
      reg_write(fpid_pkg::REG_GAIN_PROP, pick_gain(ph % 4));
      reg_write(fpid_pkg::REG_GAIN_INTEGRAL_DT, pick_gain((ph + 1) % 4));
      reg_write(fpid_pkg::REG_GAIN_DERIV_OVER_DT, pick_gain((ph + 2) % 4));
      a = pick_field();
      b = pick_field();
      case (ph % 5)
        0: begin
          lo = fpid_pkg::WORD_MIN;
          hi = fpid_pkg::WORD_MAX;
        end
        1: begin
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
        end
        2: begin
          // crossed limits
          lo = (a < b) ? b : a;
          hi = (a < b) ? a : b;
        end
        3: begin
          lo = -fpid_pkg::word_t'($urandom_range(0, 32'h0004_0000));
          hi = fpid_pkg::word_t'($urandom_range(0, 32'h0004_0000));
        end
        default: begin
          lo = a;
          hi = a;
        end
      endcase
      reg_write(fpid_pkg::REG_LIMIT_LOW, lo);
      reg_write(fpid_pkg::REG_LIMIT_HIGH, hi);
      reg_write(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                fpid_pkg::word_t'($urandom));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word($urandom_range(0, 6) == 0, pick_field(), pick_field(), pick_field(),
                  1'b0, '0);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
